### design/tfpc_pkg.sv
`timescale 1ns / 1ps
package tfpc_pkg;

   localparam int ADC_BITS        = 12;
   localparam int LOG_TABLE_DEPTH = 256;
   localparam int LOG_BITS        = $clog2(LOG_TABLE_DEPTH);
   localparam int FRAC_BITS       = 31 - LOG_BITS;

   localparam int SUPPLY_W = 13;
   localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 13'd3300;

   localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
   localparam int PROD_W      = ADC_BITS + SUPPLY_W;
   localparam int RECIP_SHIFT = PROD_W + ADC_BITS;
   localparam int RECIP_W     = RECIP_SHIFT - ADC_BITS + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / FULL_SCALE);
   localparam int MUL_W = PROD_W + RECIP_W;

   localparam logic [31:0] R_NUM    = 32'd2816000000;
   localparam logic [32:0] R_OFFSET = 33'd563200;
   localparam int DIV1_BITS   = 4;
   localparam int DIV1_STAGES = 32 / DIV1_BITS;

   localparam int LOG_W = 22;
   localparam logic [16:0] LN2_Q16   = 17'd45426;
   localparam logic [21:0] DEN_SCALE = 22'd2981500;
   localparam logic signed [47:0] DEN_BASE = 48'sd398585 * 48'sd6553600;

   localparam int TK_BITS = 18;
   localparam logic [63:0] T_NUM    = 64'd398585 * 64'd29815 * 64'd16777216;
   localparam logic [45:0] T_NUM_HI = 46'(T_NUM >> TK_BITS);
   localparam logic [TK_BITS-1:0] TK_MAX = 18'd200997;
   localparam logic [18:0] KELVIN_Q8 = 19'd69926;
   localparam logic signed [17:0] T_MAX_Q8 = 18'sd131071;
   localparam logic signed [17:0] T_LOW    = 18'sd12800;
   localparam logic signed [17:0] T_HIGH   = 18'sd20480;
   localparam logic [21:0] PWM_OFFSET = 22'd102400;
   localparam logic [10:0] PWM_MIN = 11'd600;
   localparam logic [10:0] PWM_MAX = 11'd1200;
   localparam logic signed [17:0] TC_MAX = 18'sd255;
   localparam logic signed [17:0] TC_MIN = -18'sd128;

   typedef logic [16:0] log_tab_type [0:LOG_TABLE_DEPTH];

   typedef struct packed {
      logic        valid;
      logic        oor;
      logic [31:0] r;
   } tfpc_res_type;

   typedef struct packed {
      logic               valid;
      logic               oor;
      logic signed [47:0] den;
   } tfpc_den_type;

   typedef struct packed {
      logic              valid;
      logic              oor;
      logic [10:0]       pwm;
      logic signed [8:0] tc;
   } tfpc_out_type;

   function automatic log_tab_type build_log_tab();
      log_tab_type tab;
      logic [63:0] x;
      logic [16:0] res;
      for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
         x = ((64'(LOG_TABLE_DEPTH) + 64'(k)) << 30) / LOG_TABLE_DEPTH;
         res = '0;
         for (int b = 1; b <= 16; b++) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
               x = x >> 1;
               res[16-b] = 1'b1;
            end
         end
         tab[k] = res;
      end
      tab[LOG_TABLE_DEPTH] = 17'd65536;
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();

   function automatic logic [LOG_W-1:0] log2_const(input logic [31:0] v);
      int p;
      logic [30:0] f;
      logic [LOG_BITS-1:0] idx;
      logic [FRAC_BITS-1:0] frac;
      logic [16:0] diff;
      logic [63:0] prod;
      p = 0;
      for (int b = 0; b < 32; b++) begin
         if (v[b]) p = b;
      end
      f = 31'(v << (31 - p));
      idx = f[30 -: LOG_BITS];
      frac = f[FRAC_BITS-1:0];
      diff = LOG_TAB[int'(idx) + 1] - LOG_TAB[idx];
      prod = 64'(diff) * 64'(frac);
      return LOG_W'(p * 65536) + LOG_W'(LOG_TAB[idx]) + LOG_W'(prod >> FRAC_BITS);
   endfunction

   localparam logic [LOG_W-1:0] LOG_REF = log2_const(32'd2560000);

endpackage

### design/tfpc_volt.sv
`timescale 1ns / 1ps
module tfpc_volt import tfpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                ce,
   input  logic                in_valid,
   input  logic [ADC_BITS-1:0] adc_code,
   input  logic [SUPPLY_W-1:0] supply,
   output tfpc_res_type        res
);

   logic              p1_valid_ff;
   logic [PROD_W-1:0] p1_prod_ff;
   logic              p2_valid_ff;
   logic [PROD_W-1:0] p2_prod_ff;
   logic [MUL_W-1:0]  p2_mul_ff;
   logic [SUPPLY_W-1:0] v_in;

   logic                dv_valid_ff [0:DIV1_STAGES];
   logic                dv_zero_ff  [0:DIV1_STAGES];
   logic [SUPPLY_W-1:0] dv_rem_ff   [0:DIV1_STAGES];
   logic [31:0]         dv_quo_ff   [0:DIV1_STAGES];
   logic [SUPPLY_W-1:0] dv_div_ff   [0:DIV1_STAGES];

   logic        r_valid_ff;
   logic        r_oor_ff;
   logic [32:0] r_ff;
   logic [32:0] r_in;

   // v = prod / full scale by reciprocal and one correction
   always_comb begin
      logic [SUPPLY_W-1:0] q_est;
      logic [PROD_W-1:0]   q_full;
      logic [PROD_W-1:0]   rem;
      q_est  = p2_mul_ff[RECIP_SHIFT +: SUPPLY_W];
      q_full = (PROD_W'(q_est) << ADC_BITS) - PROD_W'(q_est);
      rem    = p2_prod_ff - q_full;
      v_in   = (rem >= PROD_W'(FULL_SCALE)) ? q_est + 1'b1 : q_est;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
      end else if (ce) begin
         p1_valid_ff    <= in_valid;
         p2_valid_ff    <= p1_valid_ff;
         dv_valid_ff[0] <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         p1_prod_ff   <= PROD_W'(adc_code) * PROD_W'(supply);
         p2_prod_ff   <= p1_prod_ff;
         p2_mul_ff    <= MUL_W'(p1_prod_ff) * MUL_W'(RECIP);
         dv_zero_ff[0] <= (v_in == '0);
         dv_rem_ff[0] <= '0;
         dv_quo_ff[0] <= '0;
         dv_div_ff[0] <= v_in;
      end
   end

   for (genvar s = 0; s < DIV1_STAGES; s++) begin : g_div
      logic [SUPPLY_W-1:0] rem_in;
      logic [31:0]         quo_in;

      always_comb begin
         logic [SUPPLY_W:0] trial;
         rem_in = dv_rem_ff[s];
         quo_in = dv_quo_ff[s];
         for (int j = 0; j < DIV1_BITS; j++) begin
            trial = {rem_in, R_NUM[31 - s*DIV1_BITS - j]};
            if (trial >= {1'b0, dv_div_ff[s]}) begin
               rem_in = SUPPLY_W'(trial - {1'b0, dv_div_ff[s]});
               quo_in[31 - s*DIV1_BITS - j] = 1'b1;
            end else begin
               rem_in = SUPPLY_W'(trial);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[s+1] <= 1'b0;
         end else if (ce) begin
            dv_valid_ff[s+1] <= dv_valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            dv_zero_ff[s+1] <= dv_zero_ff[s];
            dv_rem_ff[s+1]  <= rem_in;
            dv_quo_ff[s+1]  <= quo_in;
            dv_div_ff[s+1]  <= dv_div_ff[s];
         end
      end
   end

   assign r_in = {1'b0, dv_quo_ff[DIV1_STAGES]} - R_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (ce) begin
         r_valid_ff <= dv_valid_ff[DIV1_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         r_ff     <= r_in;
         r_oor_ff <= dv_zero_ff[DIV1_STAGES] || r_in[32] || (r_in == '0);
      end
   end

   assign res.valid = r_valid_ff;
   assign res.oor   = r_oor_ff;
   assign res.r     = r_ff[31:0];

endmodule

### design/tfpc_log.sv
`timescale 1ns / 1ps
module tfpc_log import tfpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         ce,
   input  tfpc_res_type res,
   output tfpc_den_type den
);

   localparam int NST = 9;

   logic vld_ff [1:NST];
   logic oor_ff [1:NST];

   logic [4:0]  p_in;
   logic [4:0]  p1_ff;
   logic [31:0] r1_ff;
   logic [4:0]  p2_ff;
   logic [LOG_BITS-1:0]  idx2_ff;
   logic [FRAC_BITS-1:0] frac2_ff;
   logic [4:0]  p3_ff;
   logic [16:0] lo3_ff;
   logic [16:0] diff3_ff;
   logic [FRAC_BITS-1:0] frac3_ff;
   logic [4:0]  p4_ff;
   logic [16:0] lo4_ff;
   logic [16+FRAC_BITS:0] ip4_ff;
   logic signed [22:0] d5_ff;
   logic signed [39:0] m6_ff;
   logic signed [23:0] ln7_ff;
   logic signed [47:0] mm8_ff;
   logic signed [47:0] den9_ff;

   logic [31:0] norm;
   logic [LOG_W-1:0] logv;
   logic signed [22:0] d_in;
   logic signed [39:0] m_round;

   always_comb begin
      p_in = '0;
      for (int b = 0; b < 32; b++) begin
         if (res.r[b]) p_in = 5'(b);
      end
   end

   assign norm = r1_ff << (5'd31 - p1_ff);
   assign logv = LOG_W'({p4_ff, 16'b0}) + LOG_W'(lo4_ff) + LOG_W'(ip4_ff >> FRAC_BITS);
   assign d_in = $signed({1'b0, logv}) - $signed({1'b0, LOG_REF});
   assign m_round = m6_ff + (m6_ff[39] ? 40'sd65535 : 40'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= NST; i++) vld_ff[i] <= 1'b0;
      end else if (ce) begin
         vld_ff[1] <= res.valid;
         for (int i = 2; i <= NST; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         oor_ff[1] <= res.oor;
         for (int i = 2; i <= NST; i++) oor_ff[i] <= oor_ff[i-1];
         p1_ff    <= p_in;
         r1_ff    <= res.r;
         p2_ff    <= p1_ff;
         idx2_ff  <= norm[30 -: LOG_BITS];
         frac2_ff <= norm[FRAC_BITS-1:0];
         p3_ff    <= p2_ff;
         lo3_ff   <= LOG_TAB[idx2_ff];
         diff3_ff <= LOG_TAB[{1'b0, idx2_ff} + (LOG_BITS+1)'(1)] - LOG_TAB[idx2_ff];
         frac3_ff <= frac2_ff;
         p4_ff    <= p3_ff;
         lo4_ff   <= lo3_ff;
         ip4_ff   <= (17+FRAC_BITS)'(diff3_ff) * (17+FRAC_BITS)'(frac3_ff);
         d5_ff    <= d_in;
         m6_ff    <= $signed({{17{d5_ff[22]}}, d5_ff}) * $signed(40'(LN2_Q16));
         ln7_ff   <= 24'(m_round >>> 16);
         mm8_ff   <= $signed({{24{ln7_ff[23]}}, ln7_ff}) * $signed(48'(DEN_SCALE));
         den9_ff  <= DEN_BASE + mm8_ff;
      end
   end

   assign den.valid = vld_ff[NST];
   assign den.oor   = oor_ff[NST];
   assign den.den   = den9_ff;

endmodule

### design/tfpc_temp.sv
`timescale 1ns / 1ps
module tfpc_temp import tfpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         ce,
   input  tfpc_den_type den,
   output tfpc_out_type out
);

   logic                kd_valid_ff [0:TK_BITS];
   logic                kd_oor_ff   [0:TK_BITS];
   logic                kd_sat_ff   [0:TK_BITS];
   logic [45:0]         kd_rem_ff   [0:TK_BITS];
   logic [TK_BITS-1:0]  kd_quo_ff   [0:TK_BITS];
   logic [45:0]         kd_den_ff   [0:TK_BITS];

   logic               t_valid_ff;
   logic               t_oor_ff;
   logic signed [17:0] t_ff;
   logic signed [17:0] t_in;
   logic [18:0]        t_diff;

   logic               o_valid_ff;
   logic               o_oor_ff;
   logic [10:0]        o_pwm_ff;
   logic signed [8:0]  o_tc_ff;
   logic [10:0]        pwm_in;
   logic signed [8:0]  tc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         kd_valid_ff[0] <= 1'b0;
      end else if (ce) begin
         kd_valid_ff[0] <= den.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         kd_oor_ff[0] <= den.oor;
         kd_sat_ff[0] <= (den.den <= 48'sd0) || (den.den <= $signed(48'(T_NUM_HI)));
         kd_rem_ff[0] <= T_NUM_HI;
         kd_quo_ff[0] <= '0;
         kd_den_ff[0] <= den.den[45:0];
      end
   end

   for (genvar s = 0; s < TK_BITS; s++) begin : g_div
      logic [46:0] trial;
      logic        take;

      assign trial = {kd_rem_ff[s], T_NUM[TK_BITS - 1 - s]};
      assign take  = trial >= {1'b0, kd_den_ff[s]};

      always_ff @(posedge clock) begin
         if (reset) begin
            kd_valid_ff[s+1] <= 1'b0;
         end else if (ce) begin
            kd_valid_ff[s+1] <= kd_valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            kd_oor_ff[s+1] <= kd_oor_ff[s];
            kd_sat_ff[s+1] <= kd_sat_ff[s];
            kd_den_ff[s+1] <= kd_den_ff[s];
            kd_rem_ff[s+1] <= take ? 46'(trial - {1'b0, kd_den_ff[s]}) : 46'(trial);
            kd_quo_ff[s+1] <= kd_quo_ff[s] | (take ? TK_BITS'(1) << (TK_BITS - 1 - s) : '0);
         end
      end
   end

   assign t_diff = {1'b0, kd_quo_ff[TK_BITS]} - KELVIN_Q8;
   assign t_in = (kd_sat_ff[TK_BITS] || (kd_quo_ff[TK_BITS] > TK_MAX)) ? T_MAX_Q8
                 : $signed(t_diff[17:0]);

   always_comb begin
      logic signed [17:0] t_sh;
      logic [21:0]        pw;
      t_sh = t_ff >>> 8;
      pw   = 22'(t_ff[16:0]) * 22'd20 - PWM_OFFSET;
      if (t_ff < T_LOW) begin
         pwm_in = PWM_MIN;
      end else if (t_ff > T_HIGH) begin
         pwm_in = PWM_MAX;
      end else begin
         pwm_in = pw[18:8];
      end
      if (t_sh > TC_MAX) begin
         tc_in = 9'(TC_MAX);
      end else if (t_sh < TC_MIN) begin
         tc_in = 9'(TC_MIN);
      end else begin
         tc_in = 9'(t_sh);
      end
      if (t_oor_ff) begin
         pwm_in = PWM_MAX;
         tc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (ce) begin
         t_valid_ff <= kd_valid_ff[TK_BITS];
         o_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         t_oor_ff <= kd_oor_ff[TK_BITS];
         t_ff     <= t_in;
         o_oor_ff <= t_oor_ff;
         o_pwm_ff <= pwm_in;
         o_tc_ff  <= tc_in;
      end
   end

   assign out.valid = o_valid_ff;
   assign out.oor   = o_oor_ff;
   assign out.pwm   = o_pwm_ff;
   assign out.tc    = o_tc_ff;

endmodule

### design/thermistor_fan_pwm_curve_unit.sv
`timescale 1ns / 1ps
// ntc thermistor code to fan pwm compare value and temperature
// req channel: one adc code per transaction, tdata[11:0] = adc_code
// rsp channel: one result per transaction, tdata[10:0] = pwm_compare,
//   tdata[19:11] = temperature_c (signed), tuser = out_of_range
// csr port: csr_we writes csr_wdata as supply voltage in millivolts;
//   write only while no transaction is in flight
// throughput: one transaction per cycle while the output buffer is not full, set by
//   the 42-stage pipeline (8 stages of radix-16 resistance divide, 18 stages of
//   bit-serial kelvin divide, log2 table lookup and multiplies in between)
// a two-entry output buffer sits behind the pipeline; when rsp_tready is
//   low the pipeline keeps taking items until the buffer fills, then the
//   whole pipeline holds and req_tready drops; nothing is lost or repeated
// reset empties the pipeline and output buffer and sets supply to 3300 mV
module thermistor_fan_pwm_curve_unit import tfpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // adc_code[11:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // pwm_compare[10:0], temperature_c[19:11]
   output logic                rsp_tuser,   // out_of_range
   input  logic                csr_we,
   input  logic [SUPPLY_W-1:0] csr_wdata
);

   logic [SUPPLY_W-1:0] supply_ff;
   logic ce;
   tfpc_res_type res;
   tfpc_den_type den;
   tfpc_out_type pipe;

   logic         out_valid_ff;
   tfpc_out_type out_ff;
   logic         skid_valid_ff;
   tfpc_out_type skid_ff;
   logic         take;
   logic         push;

   assign ce         = !skid_valid_ff;
   assign req_tready = ce;
   assign take       = out_valid_ff && rsp_tready;
   assign push       = ce && pipe.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SUPPLY_RESET;
      end else if (csr_we) begin
         supply_ff <= csr_wdata;
      end
   end

   tfpc_volt u_volt (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (req_tvalid),
      .adc_code (req_tdata[ADC_BITS-1:0]),
      .supply   (supply_ff),
      .res      (res)
   );

   tfpc_log u_log (
      .clock (clock),
      .reset (reset),
      .ce    (ce),
      .res   (res),
      .den   (den)
   );

   tfpc_temp u_temp (
      .clock (clock),
      .reset (reset),
      .ce    (ce),
      .den   (den),
      .out   (pipe)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else begin
         if (push && out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end
         out_valid_ff <= push || (out_valid_ff && !take);
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_ff <= pipe;
         end else begin
            skid_ff <= pipe;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_ff.tc, out_ff.pwm};
   assign rsp_tuser  = out_ff.oor;

`ifndef SYNTHESIS
   a_oor_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[10:0] == PWM_MAX && rsp_tdata[19:11] == '0)
      else $error("out of range result with wrong outputs");

   a_pwm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:0] >= PWM_MIN && rsp_tdata[10:0] <= PWM_MAX)
      else $error("pwm compare outside curve");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !take |=> skid_valid_ff && !req_tready)
      else $error("skid entry dropped while stalled");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import tfpc_pkg::*;

   localparam int LIMIT_CYCLES = 400000;

   typedef struct {
      logic [10:0]       pwm;
      logic signed [8:0] tc;
      logic              oor;
   } fan_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;
   logic                rsp_tuser;
   logic                csr_we = 1'b0;
   logic [SUPPLY_W-1:0] csr_wdata = '0;

   logic [11:0]    code_q[$];
   fan_result_type expected_q[$];
   logic [16:0]    ln_tab [0:256];
   longint         ln_ref;
   logic [12:0]    supply_mv = 13'd3300;
   int             errors = 0;
   int             cycles = 0;
   int             tx_gap = 0;
   int             rx_stall = 0;
   bit             calm = 1'b0;
   bit             hold_tx = 1'b0;

   thermistor_fan_pwm_curve_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint log2_fix(longint v);
      int p;
      longint unsigned f, pos, idx, rem, lo, hi;
      p = 31;
      while (p > 0 && ((v >> p) & 1) == 0) p--;
      f = ((longint'(v) << (63 - p)) >> 32) & 64'h7FFF_FFFF;
      pos = f * 256;
      idx = pos >> 31;
      if (idx >= 256) idx = 255;
      rem = pos & 64'h7FFF_FFFF;
      lo = ln_tab[idx];
      hi = ln_tab[idx + 1];
      return longint'(p) * 65536 + longint'(lo) + longint'(((hi - lo) * rem) >> 31);
   endfunction

   function automatic fan_result_type fan_curve(logic [11:0] code, logic [12:0] supply);
      fan_result_type res;
      longint unsigned v_mv, num, tk;
      longint r, d, ln, den, t, tc;
      v_mv = (64'(code) * 64'(supply)) / 4095;
      res.oor = 1'b1;
      res.pwm = 11'd1200;
      res.tc = '0;
      if (v_mv == 0) return res;
      r = longint'((64'd11000000 * 256) / v_mv) - 2200 * 256;
      if (r <= 0) return res;
      d = log2_fix(r) - ln_ref;
      ln = (d * 45426) / 65536;
      den = 64'sd398585 * 6553600 + 64'sd2981500 * ln;
      if (den <= 0) t = 131071;
      else begin
         num = 64'd398585 * 29815 * 16777216;
         tk = num / longint'(den);
         if (tk > 131071 + 69926) t = 131071;
         else t = longint'(tk) - 69926;
      end
      if (t < 12800) res.pwm = 11'd600;
      else if (t > 20480) res.pwm = 11'd1200;
      else res.pwm = 11'((20 * t - 102400) >>> 8);
      if (t >= 0) tc = t / 256;
      else tc = -((-t + 255) / 256);
      if (tc > 255) tc = 255;
      if (tc < -128) tc = -128;
      res.tc = 9'(tc);
      res.oor = 1'b0;
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
               req_tvalid <= 1'b0;
            end else if (code_q.size() > 0 && !hold_tx) begin
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0, code_q[0]};
               expected_q.push_back(fan_curve(code_q[0], supply_mv));
               void'(code_q.pop_front());
               if (!calm && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 18);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 11) == 0) rx_stall <= $urandom_range(1, 18);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected transaction tdata=%h", rsp_tdata);
            errors <= errors + 1;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[10:0] !== want.pwm) begin
               $error("pwm_compare expected %0d actual %0d", want.pwm, rsp_tdata[10:0]);
               errors <= errors + 1;
            end
            if (rsp_tdata[19:11] !== want.tc) begin
               $error("temperature_c expected %0d actual %0d", want.tc,
                      $signed(rsp_tdata[19:11]));
               errors <= errors + 1;
            end
            if (rsp_tuser !== want.oor) begin
               $error("out_of_range expected %0b actual %0b", want.oor, rsp_tuser);
               errors <= errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic wait_drained();
      while (code_q.size() > 0 || req_tvalid || expected_q.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_supply(logic [12:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      supply_mv <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_codes(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: code_q.push_back(12'($urandom_range(0, 40)));
            1: code_q.push_back(12'($urandom_range(4050, 4095)));
            default: code_q.push_back(12'($urandom));
         endcase
      end
   endtask

   initial begin
      logic [11:0] directed [] = '{12'd0, 12'd1, 12'd2, 12'd4095, 12'd4094, 12'hAAA,
                                   12'h555, 12'd2048, 12'd1500, 12'd1200, 12'd1000,
                                   12'd1700, 12'd2500, 12'd3000, 12'd800, 12'd100};
      logic [12:0] supplies [] = '{13'd1000, 13'd6000, 13'h1FFF, 13'd0, 13'd1, 13'd5000};
      for (int k = 0; k < 256; k++) begin
         longint unsigned x;
         logic [16:0] acc;
         x = ((64'd256 + k) << 30) / 256;
         acc = '0;
         for (int b = 1; b <= 16; b++) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
               x = x >> 1;
               acc[16-b] = 1'b1;
            end
         end
         ln_tab[k] = acc;
      end
      ln_tab[256] = 17'd65536;
      ln_ref = log2_fix(2560000);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) code_q.push_back(directed[i]);
      random_codes(250);
      wait_drained();
      foreach (supplies[s]) begin
         write_supply(supplies[s]);
         foreach (directed[i]) if (i < 4) code_q.push_back(directed[i]);
         random_codes(110);
         wait_drained();
      end
      write_supply(13'($urandom_range(1000, 6000)));
      hold_tx = 1'b1;
      random_codes(20);
      repeat (30) @(posedge clock);
      hold_tx = 1'b0;
      random_codes(60);
      while (code_q.size() > 20) @(posedge clock);
      // sender waits until the pipeline fully drains
      hold_tx = 1'b1;
      while (req_tvalid || expected_q.size() > 0) @(posedge clock);
      hold_tx = 1'b0;
      calm = 1'b1;
      random_codes(100);
      wait_drained();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
design/tfpc_pkg.sv
design/tfpc_volt.sv
design/tfpc_log.sv
design/tfpc_temp.sv
design/thermistor_fan_pwm_curve_unit.sv
tb/testbench.sv
